>>> rtl/core/tpcc_pkg.sv
`default_nettype none

package tpcc_pkg;

   localparam int MODE_W = 3;
   localparam int CHAN_W = 4;
   localparam int CUR_W  = 24;
   localparam int GAIN_W = 32;
   localparam int SPAN_W = 23;
   localparam int FRAC_W = 24;
   localparam int MAG_W  = CUR_W + 1;
   localparam int PROD_W = GAIN_W + 1 + CUR_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int RND_W  = SUM_W - FRAC_W;

   localparam logic [GAIN_W-1:0]       GAIN_ONE       = 32'h0100_0000;
   localparam logic [SPAN_W-1:0]       MIN_SPAN_RESET = 23'd6554;
   localparam logic signed [CUR_W-1:0] CUR_MAX        = 24'sh7F_FFFF;
   localparam logic signed [CUR_W-1:0] CUR_MIN        = 24'sh80_0000;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPLY     = 3'd0,
      MODE_SET_ONE   = 3'd1,
      MODE_SET_TWO   = 3'd2,
      MODE_COMPUTE   = 3'd3,
      MODE_CLEAR_CH  = 3'd4,
      MODE_CLEAR_ALL = 3'd5
   } mode_type;

endpackage

`default_nettype wire

>>> rtl/core/tpcc_if.sv
`default_nettype none

interface tpcc_req_if;
   import tpcc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [CHAN_W-1:0]        channel;
   logic signed [CUR_W-1:0]  raw_current;
   logic signed [CUR_W-1:0]  reference_current;

   modport source (output valid, mode, channel, raw_current, reference_current, input ready);
   modport sink (input valid, mode, channel, raw_current, reference_current, output ready);
endinterface

interface tpcc_rsp_if;
   import tpcc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CUR_W-1:0]  corrected_current;
   logic                     success;
   logic                     has_point_one;
   logic                     has_point_two;
   logic                     is_calibrated;
   logic [GAIN_W-1:0]        gain;
   logic signed [CUR_W-1:0]  bias;

   modport source (output valid, corrected_current, success, has_point_one, has_point_two,
                   is_calibrated, gain, bias, input ready);
   modport sink (input valid, corrected_current, success, has_point_one, has_point_two,
                 is_calibrated, gain, bias, output ready);
endinterface

interface tpcc_csr_if;
   import tpcc_pkg::*;
   logic               valid;
   logic               ready;
   logic [SPAN_W-1:0]  min_raw_span;

   modport source (output valid, min_raw_span, input ready);
   modport sink (input valid, min_raw_span, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tpcc_div.sv
`default_nettype none

module tpcc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tpcc_pkg::MAG_W-1:0]    numer,
   input  wire logic [tpcc_pkg::MAG_W-1:0]    denom,
   output logic                               done,
   output logic [tpcc_pkg::GAIN_W-1:0]        quotient
);
   import tpcc_pkg::*;

   localparam int CNT_W = $clog2(GAIN_W);
   localparam int HI_W  = GAIN_W - FRAC_W;

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [MAG_W-1:0]  rem_ff;
   logic [MAG_W-1:0]  denom_ff;
   logic [GAIN_W-1:0] shift_ff;
   logic [MAG_W:0]    shifted;
   logic [MAG_W:0]    trial;
   logic              fits;

   assign shifted  = {rem_ff, shift_ff[GAIN_W-1]};
   assign trial    = shifted - {1'b0, denom_ff};
   assign fits     = shifted >= {1'b0, denom_ff};
   assign done     = done_ff;
   assign quotient = shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(GAIN_W - 1);
            rem_ff   <= numer >> HI_W;
            denom_ff <= denom;
            shift_ff <= {numer[HI_W-1:0], {FRAC_W{1'b0}}};
         end else if (busy_ff) begin
            rem_ff   <= fits ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
            shift_ff <= {shift_ff[GAIN_W-2:0], fits};
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/two_point_channel_calibration.sv
// Two-point gain and offset calibration for a set of current channels.
//
// req_chan carries one request: mode, channel, raw and reference current
// (signed Q7.16 mA). Each request yields exactly one response on rsp_chan:
// corrected current, success, the channel flags, slope (Q8.24) and offset.
// csr_chan writes min_raw_span; it is always ready. It must be written only
// while no request is in flight; the block itself does not enforce this.
//
// Requests are handled one at a time; req_chan.ready is high only while the
// sequencer waits for work, from the cycle after a response load. The load
// follows decode for point set, clear and pass-through. Apply on a calibrated
// channel then passes the multiply, sum, round and finish states; compute
// passes span and check and, if the check passes, the radix-2 restoring
// divider, one quotient bit per cycle for 32 bits, then one pass through
// the shared multiplier and the rounding adder, which apply also uses.
//
// A held response does not block acceptance: the next request is taken and
// worked on, and only its final load waits for rsp_chan.ready.
// Synchronous reset clears every channel to slope 1.0, offset 0, no points,
// and sets min_raw_span to 6554 (0.1 mA).
`default_nettype none

module two_point_channel_calibration #(
   parameter int CHANNELS = 8
) (
   input wire logic    clock,
   input wire logic    reset,
   tpcc_req_if.sink    req_chan,
   tpcc_rsp_if.source  rsp_chan,
   tpcc_csr_if.sink    csr_chan
);
   import tpcc_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [SUM_W-1:0] HALF_UP   = SUM_W'(1) << (FRAC_W - 1);
   localparam logic [SUM_W-1:0] HALF_DOWN = HALF_UP - 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SPAN,
      S_CHECK,
      S_DIV,
      S_MUL,
      S_SUM,
      S_ROUND,
      S_FINISH,
      S_REPLY
   } state_type;

   state_type          state_ff;
   mode_type           mode_ff;
   logic               chan_ok_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [CUR_W-1:0]   raw_ff;
   logic [CUR_W-1:0]   ref_ff;
   logic [SPAN_W-1:0]  min_span_ff;

   logic [CUR_W-1:0]   raw1_ff [CHANNELS];
   logic [CUR_W-1:0]   ref1_ff [CHANNELS];
   logic [CUR_W-1:0]   raw2_ff [CHANNELS];
   logic [CUR_W-1:0]   ref2_ff [CHANNELS];
   logic [GAIN_W-1:0]  gain_ff [CHANNELS];
   logic [CUR_W-1:0]   bias_ff [CHANNELS];
   logic [CHANNELS-1:0] p1_ff;
   logic [CHANNELS-1:0] p2_ff;
   logic [CHANNELS-1:0] cal_ff;

   logic [MAG_W-1:0]   rs_ff;
   logic [MAG_W-1:0]   fs_ff;
   logic [MAG_W-1:0]   rm_ff;
   logic [MAG_W-1:0]   fm_ff;
   logic               rs_neg_ff;
   logic               fs_neg_ff;
   logic               fs_zero_ff;
   logic               div_start_ff;
   logic [GAIN_W-1:0]  quot_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [RND_W-1:0]   rnd_ff;
   logic [CUR_W-1:0]   corr_ff;
   logic               ok_ff;

   logic               rsp_valid_ff;
   logic [CUR_W-1:0]   rsp_corr_ff;
   logic               rsp_ok_ff;
   logic               rsp_p1_ff;
   logic               rsp_p2_ff;
   logic               rsp_cal_ff;
   logic [GAIN_W-1:0]  rsp_gain_ff;
   logic [CUR_W-1:0]   rsp_bias_ff;

   logic               is_apply;
   logic               div_done;
   logic [GAIN_W-1:0]  div_quot;
   logic signed [GAIN_W:0]   mul_a;
   logic signed [CUR_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [SUM_W-1:0]   addend;
   logic [SUM_W-1:0]   rounded;
   logic [RND_W:0]     offset;
   logic               offset_fits;
   logic               rnd_fits;
   logic [CUR_W-1:0]   sat_value;
   logic               check_fail;
   logic               reply_go;
   logic               cal_bad;

   tpcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .numer    (fm_ff),
      .denom    (rm_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign is_apply = (mode_ff == MODE_APPLY);
   assign reply_go = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      mul_a = is_apply ? $signed({1'b0, gain_ff[idx_ff]}) : $signed({1'b0, quot_ff});
      mul_b = is_apply ? $signed(raw_ff) : $signed(raw1_ff[idx_ff]);
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      addend = '0;
      if (is_apply) begin
         addend = {{(SUM_W - CUR_W - FRAC_W){bias_ff[idx_ff][CUR_W-1]}},
                   bias_ff[idx_ff], {FRAC_W{1'b0}}};
      end
      rounded = sum_ff + (sum_ff[SUM_W-1] ? HALF_DOWN : HALF_UP);
   end

   always_comb begin
      offset = {{(RND_W + 1 - CUR_W){ref1_ff[idx_ff][CUR_W-1]}}, ref1_ff[idx_ff]}
             - {rnd_ff[RND_W-1], rnd_ff};
      offset_fits = (&offset[RND_W:CUR_W-1]) || !(|offset[RND_W:CUR_W-1]);
      rnd_fits    = (&rnd_ff[RND_W-1:CUR_W-1]) || !(|rnd_ff[RND_W-1:CUR_W-1]);
      if (rnd_fits) begin
         sat_value = rnd_ff[CUR_W-1:0];
      end else if (rnd_ff[RND_W-1]) begin
         sat_value = CUR_MIN;
      end else begin
         sat_value = CUR_MAX;
      end
   end

   always_comb begin
      check_fail = !(p1_ff[idx_ff] && p2_ff[idx_ff])
                || (rm_ff <= MAG_W'(min_span_ff))
                || fs_zero_ff
                || (rs_neg_ff != fs_neg_ff)
                || ({8'd0, fm_ff} >= {rm_ff, 8'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_span_ff <= MIN_SPAN_RESET;
      end else if (csr_chan.valid) begin
         min_span_ff <= csr_chan.min_raw_span;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            raw1_ff[i] <= '0;
            ref1_ff[i] <= '0;
            raw2_ff[i] <= '0;
            ref2_ff[i] <= '0;
            gain_ff[i] <= GAIN_ONE;
            bias_ff[i] <= '0;
         end
         p1_ff  <= '0;
         p2_ff  <= '0;
         cal_ff <= '0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  mode_ff    <= mode_type'(req_chan.mode);
                  chan_ok_ff <= {1'b0, req_chan.channel} < (CHAN_W + 1)'(CHANNELS);
                  idx_ff     <= req_chan.channel[IDX_W-1:0];
                  raw_ff     <= req_chan.raw_current;
                  ref_ff     <= req_chan.reference_current;
                  corr_ff    <= '0;
                  ok_ff      <= 1'b0;
                  state_ff   <= S_DECODE;
               end
            end
            S_DECODE: begin
               state_ff <= S_REPLY;
               case (mode_ff)
                  MODE_APPLY: begin
                     if (chan_ok_ff && cal_ff[idx_ff]) begin
                        state_ff <= S_MUL;
                     end else begin
                        corr_ff <= raw_ff;
                     end
                  end
                  MODE_SET_ONE: begin
                     if (chan_ok_ff) begin
                        raw1_ff[idx_ff] <= raw_ff;
                        ref1_ff[idx_ff] <= ref_ff;
                        p1_ff[idx_ff]   <= 1'b1;
                        cal_ff[idx_ff]  <= 1'b0;
                     end
                     ok_ff <= chan_ok_ff;
                  end
                  MODE_SET_TWO: begin
                     if (chan_ok_ff) begin
                        raw2_ff[idx_ff] <= raw_ff;
                        ref2_ff[idx_ff] <= ref_ff;
                        p2_ff[idx_ff]   <= 1'b1;
                        cal_ff[idx_ff]  <= 1'b0;
                     end
                     ok_ff <= chan_ok_ff;
                  end
                  MODE_COMPUTE: begin
                     if (chan_ok_ff) begin
                        rs_ff <= {raw2_ff[idx_ff][CUR_W-1], raw2_ff[idx_ff]}
                               - {raw1_ff[idx_ff][CUR_W-1], raw1_ff[idx_ff]};
                        fs_ff <= {ref2_ff[idx_ff][CUR_W-1], ref2_ff[idx_ff]}
                               - {ref1_ff[idx_ff][CUR_W-1], ref1_ff[idx_ff]};
                        state_ff <= S_SPAN;
                     end
                  end
                  MODE_CLEAR_CH: begin
                     if (chan_ok_ff) begin
                        raw1_ff[idx_ff] <= '0;
                        ref1_ff[idx_ff] <= '0;
                        raw2_ff[idx_ff] <= '0;
                        ref2_ff[idx_ff] <= '0;
                        gain_ff[idx_ff] <= GAIN_ONE;
                        bias_ff[idx_ff] <= '0;
                        p1_ff[idx_ff]   <= 1'b0;
                        p2_ff[idx_ff]   <= 1'b0;
                        cal_ff[idx_ff]  <= 1'b0;
                     end
                     ok_ff <= chan_ok_ff;
                  end
                  MODE_CLEAR_ALL: begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        raw1_ff[i] <= '0;
                        ref1_ff[i] <= '0;
                        raw2_ff[i] <= '0;
                        ref2_ff[i] <= '0;
                        gain_ff[i] <= GAIN_ONE;
                        bias_ff[i] <= '0;
                     end
                     p1_ff  <= '0;
                     p2_ff  <= '0;
                     cal_ff <= '0;
                     ok_ff  <= 1'b1;
                  end
                  default: begin
                     ok_ff <= 1'b0;
                  end
               endcase
            end
            S_SPAN: begin
               rs_neg_ff  <= rs_ff[MAG_W-1];
               fs_neg_ff  <= fs_ff[MAG_W-1];
               fs_zero_ff <= (fs_ff == '0);
               rm_ff      <= rs_ff[MAG_W-1] ? (~rs_ff + 1'b1) : rs_ff;
               fm_ff      <= fs_ff[MAG_W-1] ? (~fs_ff + 1'b1) : fs_ff;
               state_ff   <= S_CHECK;
            end
            S_CHECK: begin
               if (check_fail) begin
                  gain_ff[idx_ff] <= GAIN_ONE;
                  bias_ff[idx_ff] <= '0;
                  cal_ff[idx_ff]  <= 1'b0;
                  state_ff        <= S_REPLY;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  quot_ff <= div_quot;
                  if (div_quot == '0) begin
                     gain_ff[idx_ff] <= GAIN_ONE;
                     bias_ff[idx_ff] <= '0;
                     cal_ff[idx_ff]  <= 1'b0;
                     state_ff        <= S_REPLY;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               sum_ff   <= {prod_ff[PROD_W-1], prod_ff} + addend;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               rnd_ff   <= rounded[SUM_W-1:FRAC_W];
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               state_ff <= S_REPLY;
               if (is_apply) begin
                  corr_ff <= sat_value;
                  ok_ff   <= 1'b1;
               end else if (offset_fits) begin
                  gain_ff[idx_ff] <= quot_ff;
                  bias_ff[idx_ff] <= offset[CUR_W-1:0];
                  cal_ff[idx_ff]  <= 1'b1;
                  ok_ff           <= 1'b1;
               end else begin
                  gain_ff[idx_ff] <= GAIN_ONE;
                  bias_ff[idx_ff] <= '0;
                  cal_ff[idx_ff]  <= 1'b0;
               end
            end
            S_REPLY: begin
               if (reply_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_corr_ff  <= corr_ff;
                  rsp_ok_ff    <= ok_ff;
                  rsp_p1_ff    <= chan_ok_ff && p1_ff[idx_ff];
                  rsp_p2_ff    <= chan_ok_ff && p2_ff[idx_ff];
                  rsp_cal_ff   <= chan_ok_ff && cal_ff[idx_ff];
                  rsp_gain_ff  <= chan_ok_ff ? gain_ff[idx_ff] : GAIN_ONE;
                  rsp_bias_ff  <= chan_ok_ff ? bias_ff[idx_ff] : '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready             = (state_ff == S_IDLE);
   assign csr_chan.ready             = 1'b1;
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.corrected_current = rsp_corr_ff;
   assign rsp_chan.success           = rsp_ok_ff;
   assign rsp_chan.has_point_one     = rsp_p1_ff;
   assign rsp_chan.has_point_two     = rsp_p2_ff;
   assign rsp_chan.is_calibrated     = rsp_cal_ff;
   assign rsp_chan.gain              = rsp_gain_ff;
   assign rsp_chan.bias              = rsp_bias_ff;

   always_comb begin
      cal_bad = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (cal_ff[i] && (!p1_ff[i] || !p2_ff[i] || gain_ff[i] == '0)) begin
            cal_bad = 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff == S_DECODE)
      else $error("accepted request did not enter decode");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide wait");

   a_cal_consistent: assert property (@(posedge clock) disable iff (reset)
      !cal_bad)
      else $error("calibrated channel lacks a point or has zero slope");

   a_reply_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REPLY && reply_go |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("response not loaded on reply");
`endif

endmodule

`default_nettype wire

>>> dv/two_point_channel_calibration_test.sv
`default_nettype none

module two_point_channel_calibration_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tpcc_pkg::*;

   localparam int CHANNELS    = 8;
   localparam int CYCLE_LIMIT = 800000;
   localparam int DRAIN_WAIT  = 60;
   localparam int HOLD_CYCLES = 400;

   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic [CHAN_W-1:0]       channel;
      logic signed [CUR_W-1:0] raw;
      logic signed [CUR_W-1:0] reference;
   } cal_request_type;

   typedef struct {
      logic signed [CUR_W-1:0] corrected;
      logic                    success;
      logic                    has_one;
      logic                    has_two;
      logic                    calibrated;
      logic [GAIN_W-1:0]       gain;
      logic signed [CUR_W-1:0] bias;
   } cal_result_type;

   logic clock;
   logic reset;

   tpcc_req_if req_chan ();
   tpcc_rsp_if rsp_chan ();
   tpcc_csr_if csr_chan ();

   two_point_channel_calibration #(.CHANNELS(CHANNELS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // calibration state mirror
   logic signed [CUR_W-1:0] point_one_raw [CHANNELS];
   logic signed [CUR_W-1:0] point_one_ref [CHANNELS];
   logic signed [CUR_W-1:0] point_two_raw [CHANNELS];
   logic signed [CUR_W-1:0] point_two_ref [CHANNELS];
   logic [GAIN_W-1:0]       slope_q24     [CHANNELS];
   logic signed [CUR_W-1:0] offset_q16    [CHANNELS];
   logic                    have_one      [CHANNELS];
   logic                    have_two      [CHANNELS];
   logic                    calibrated    [CHANNELS];
   logic [SPAN_W-1:0]       span_floor;

   cal_request_type pending_requests [$];
   cal_result_type  expected_results [$];
   cal_request_type req_shown;

   int  req_gap;
   int  rsp_gap;
   bit  req_idle_on;
   bit  rsp_idle_on;
   logic rsp_hold;

   int error_count;
   int cycle_count;
   int n_queued;
   int n_accepted;
   int n_responses;
   int n_span_settings;
   int n_calibrated;
   int n_cal_rejected;
   int n_apply_cal;
   int n_saturated;

   always #5 clock = ~clock;

   function automatic longint round_frac(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + 64'sd8388608) >>> 24;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clip_cur(longint v);
      if (v > longint'(CUR_MAX)) return longint'(CUR_MAX);
      if (v < longint'(CUR_MIN)) return longint'(CUR_MIN);
      return v;
   endfunction

   function automatic void reset_channel(int c);
      point_one_raw[c] = '0;
      point_one_ref[c] = '0;
      point_two_raw[c] = '0;
      point_two_ref[c] = '0;
      slope_q24[c]     = GAIN_ONE;
      offset_q16[c]    = '0;
      have_one[c]      = 1'b0;
      have_two[c]      = 1'b0;
      calibrated[c]    = 1'b0;
   endfunction

   function automatic bit calibrate_channel(int c);
      longint rs, fs, rm, fm, q, off;
      slope_q24[c]  = GAIN_ONE;
      offset_q16[c] = '0;
      calibrated[c] = 1'b0;
      if (!(have_one[c] && have_two[c])) return 1'b0;
      rs = longint'(point_two_raw[c]) - longint'(point_one_raw[c]);
      fs = longint'(point_two_ref[c]) - longint'(point_one_ref[c]);
      rm = (rs < 0) ? -rs : rs;
      if (rm <= longint'(span_floor)) return 1'b0;
      if (fs == 0 || ((fs < 0) != (rs < 0))) return 1'b0;
      fm = (fs < 0) ? -fs : fs;
      q  = (fm <<< 24) / rm;
      if (q == 0 || q > 64'sd4294967295) return 1'b0;
      off = longint'(point_one_ref[c]) - round_frac(q * longint'(point_one_raw[c]));
      if (off > longint'(CUR_MAX) || off < longint'(CUR_MIN)) return 1'b0;
      slope_q24[c]  = q[GAIN_W-1:0];
      offset_q16[c] = off[CUR_W-1:0];
      calibrated[c] = 1'b1;
      return 1'b1;
   endfunction

   function automatic cal_result_type predict_result(cal_request_type rq);
      cal_result_type r;
      bit     in_range;
      bit     ok;
      int     c;
      longint corr;
      longint v;
      in_range = (rq.channel < CHANNELS);
      c        = in_range ? int'(rq.channel) : 0;
      ok       = 1'b0;
      corr     = 0;
      case (rq.mode)
         MODE_APPLY: begin
            corr = longint'(rq.raw);
            if (in_range && calibrated[c]) begin
               v = longint'(slope_q24[c]) * longint'(rq.raw)
                 + longint'(offset_q16[c]) * 64'sd16777216;
               corr = round_frac(v);
               if (corr != clip_cur(corr)) n_saturated++;
               corr = clip_cur(corr);
               ok = 1'b1;
               n_apply_cal++;
            end
         end
         MODE_SET_ONE: begin
            if (in_range) begin
               point_one_raw[c] = rq.raw;
               point_one_ref[c] = rq.reference;
               have_one[c]      = 1'b1;
               calibrated[c]    = 1'b0;
               ok = 1'b1;
            end
         end
         MODE_SET_TWO: begin
            if (in_range) begin
               point_two_raw[c] = rq.raw;
               point_two_ref[c] = rq.reference;
               have_two[c]      = 1'b1;
               calibrated[c]    = 1'b0;
               ok = 1'b1;
            end
         end
         MODE_COMPUTE: begin
            if (in_range) begin
               ok = calibrate_channel(c);
               if (ok) n_calibrated++;
               else n_cal_rejected++;
            end
         end
         MODE_CLEAR_CH: begin
            if (in_range) begin
               reset_channel(c);
               ok = 1'b1;
            end
         end
         MODE_CLEAR_ALL: begin
            for (int i = 0; i < CHANNELS; i++) reset_channel(i);
            ok = 1'b1;
         end
         default: ok = 1'b0;
      endcase
      r.corrected = corr[CUR_W-1:0];
      r.success   = ok;
      if (in_range) begin
         r.has_one    = have_one[c];
         r.has_two    = have_two[c];
         r.calibrated = calibrated[c];
         r.gain       = slope_q24[c];
         r.bias       = offset_q16[c];
      end else begin
         r.has_one    = 1'b0;
         r.has_two    = 1'b0;
         r.calibrated = 1'b0;
         r.gain       = GAIN_ONE;
         r.bias       = '0;
      end
      return r;
   endfunction

   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < 40)
         $display("mismatch at response %0d: %s got %h expected %h",
                  n_responses, what, got, want);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(predict_result(req_shown));
            n_accepted++;
            req_gap = pick_gap(req_idle_on);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_shown = pending_requests.pop_front();
               req_chan.valid             <= 1'b1;
               req_chan.mode              <= req_shown.mode;
               req_chan.channel           <= req_shown.channel;
               req_chan.raw_current       <= req_shown.raw;
               req_chan.reference_current <= req_shown.reference;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      cal_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            n_responses++;
            if (expected_results.size() == 0) begin
               report_mismatch("response with no request", 64'(rsp_chan.corrected_current),
                               '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.corrected_current !== want.corrected)
                  report_mismatch("corrected_current", 64'(rsp_chan.corrected_current),
                                  64'(want.corrected));
               if (rsp_chan.success !== want.success)
                  report_mismatch("success", 64'(rsp_chan.success), 64'(want.success));
               if (rsp_chan.has_point_one !== want.has_one)
                  report_mismatch("has_point_one", 64'(rsp_chan.has_point_one),
                                  64'(want.has_one));
               if (rsp_chan.has_point_two !== want.has_two)
                  report_mismatch("has_point_two", 64'(rsp_chan.has_point_two),
                                  64'(want.has_two));
               if (rsp_chan.is_calibrated !== want.calibrated)
                  report_mismatch("is_calibrated", 64'(rsp_chan.is_calibrated),
                                  64'(want.calibrated));
               if (rsp_chan.gain !== want.gain)
                  report_mismatch("gain", 64'(rsp_chan.gain), 64'(want.gain));
               if (rsp_chan.bias !== want.bias)
                  report_mismatch("bias", 64'(rsp_chan.bias), 64'(want.bias));
            end
            rsp_gap = pick_gap(rsp_idle_on);
         end else if (rsp_gap > 0) begin
            rsp_gap--;
         end else if (rsp_idle_on && $urandom_range(0, 15) == 0) begin
            rsp_gap = $urandom_range(1, 4);
         end
         rsp_chan.ready <= (rsp_gap == 0) && !rsp_hold;
      end
   end

   // hold off responses long enough to back up the request side
   initial begin : response_hold
      rsp_hold = 1'b0;
      wait (n_accepted >= 150);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run did not drain within %0d cycles", CYCLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_request(logic [MODE_W-1:0] m, int ch, longint raw, longint refc);
      cal_request_type rq;
      rq.mode      = m;
      rq.channel   = ch[CHAN_W-1:0];
      rq.raw       = raw[CUR_W-1:0];
      rq.reference = refc[CUR_W-1:0];
      pending_requests.push_back(rq);
      n_queued++;
   endtask

   function automatic longint rand_cur();
      logic signed [CUR_W-1:0] v;
      v = CUR_W'($urandom());
      return longint'(v);
   endfunction

   function automatic longint apply_raw();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return longint'($urandom_range(0, 1 << 22)) - (1 << 21);
      if (r < 9) return rand_cur();
      return $urandom_range(0, 1) ? longint'(CUR_MAX) : longint'(CUR_MIN);
   endfunction

   task automatic add_calibration_run();
      int     ch;
      int     order;
      int     pick;
      longint raw1, raw2, ref1, ref2, mag, fmag, dir;
      ch = ($urandom_range(0, 9) == 0) ? int'($urandom_range(CHANNELS, 15))
                                        : int'($urandom_range(0, CHANNELS - 1));
      raw1 = ($urandom_range(0, 3) == 0) ? rand_cur()
           : longint'($urandom_range(0, 1 << 22)) - (1 << 21);
      pick = $urandom_range(0, 9);
      if (pick == 0)      mag = longint'(span_floor);
      else if (pick == 1) mag = longint'(span_floor) + 1;
      else if (pick == 2) mag = longint'($urandom_range(0, span_floor));
      else                mag = longint'(span_floor) + longint'($urandom_range(1, 1 << 20));
      dir = (raw1 >= 0) ? -1 : 1;
      if ($urandom_range(0, 3) == 0) dir = -dir;
      raw2 = clip_cur(raw1 + dir * mag);
      pick = $urandom_range(0, 19);
      if (pick == 0)      fmag = 0;
      else if (pick == 1) fmag = mag * longint'($urandom_range(256, 600));
      else                fmag = (mag * longint'($urandom_range(1, 1024))) / 256;
      ref1 = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      ref2 = clip_cur(ref1 + ((pick == 2) ? -dir : dir) * fmag);
      order = $urandom_range(0, 9);
      if (order == 2) begin
         queue_request(MODE_SET_TWO, ch, raw2, ref2);
         queue_request(MODE_SET_ONE, ch, raw1, ref1);
      end else begin
         if (order != 0) queue_request(MODE_SET_ONE, ch, raw1, ref1);
         if (order != 1) queue_request(MODE_SET_TWO, ch, raw2, ref2);
      end
      queue_request(MODE_COMPUTE, ch, rand_cur(), rand_cur());
      repeat ($urandom_range(1, 5)) queue_request(MODE_APPLY, ch, apply_raw(), rand_cur());
      pick = $urandom_range(0, 39);
      case (pick)
         0, 1: queue_request(MODE_CLEAR_CH, ch, rand_cur(), rand_cur());
         2: queue_request(MODE_CLEAR_ALL, $urandom_range(0, 15), rand_cur(), rand_cur());
         3, 4, 5, 6: begin
            queue_request(MODE_SET_ONE, ch, raw1, ref1);
            queue_request(MODE_APPLY, ch, apply_raw(), rand_cur());
         end
         7, 8, 9, 10:
            queue_request(MODE_APPLY, $urandom_range(0, 15), apply_raw(), rand_cur());
         default: ;
      endcase
   endtask

   task automatic add_random(int n);
      int goal;
      goal = n_queued + n;
      while (n_queued < goal) begin
         if ($urandom_range(0, 99) < 15)
            queue_request(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 15), rand_cur(),
                          rand_cur());
         else
            add_calibration_run();
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_requests.size() > 0 || req_chan.valid || expected_results.size() > 0)
         @(negedge clock);
   endtask

   task automatic program_span(logic [SPAN_W-1:0] value);
      @(posedge clock);
      csr_chan.valid        <= 1'b1;
      csr_chan.min_raw_span <= value;
      do @(posedge clock); while (!csr_chan.ready);
      span_floor = value;
      n_span_settings++;
      csr_chan.valid <= 1'b0;
   endtask

   initial begin : stimulus
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid             = 1'b0;
      req_chan.mode              = '0;
      req_chan.channel           = '0;
      req_chan.raw_current       = '0;
      req_chan.reference_current = '0;
      rsp_chan.ready             = 1'b0;
      csr_chan.valid             = 1'b0;
      csr_chan.min_raw_span      = '0;
      for (int i = 0; i < CHANNELS; i++) reset_channel(i);
      span_floor      = MIN_SPAN_RESET;
      n_span_settings = 1;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_request(MODE_APPLY, 0, longint'(CUR_MAX), 0);
      queue_request(MODE_APPLY, 15, longint'(CUR_MIN), 0);
      queue_request(MODE_SET_ONE, 15, 1000, 2000);
      queue_request(MODE_COMPUTE, 0, 0, 0);
      queue_request(MODE_SET_ONE, 0, 0, 0);
      queue_request(MODE_SET_TWO, 0, 6554, 100);
      queue_request(MODE_COMPUTE, 0, 0, 0);
      queue_request(MODE_SET_TWO, 0, 6555, 13110);
      queue_request(MODE_COMPUTE, 0, 0, 0);
      queue_request(MODE_APPLY, 0, longint'(CUR_MAX), 0);
      queue_request(MODE_APPLY, 0, longint'(CUR_MIN), 0);
      queue_request(MODE_SET_ONE, 1, 0, 100000);
      queue_request(MODE_SET_TWO, 1, 100000, 0);
      queue_request(MODE_COMPUTE, 1, 0, 0);
      queue_request(MODE_SET_ONE, 2, 0, longint'(CUR_MIN));
      queue_request(MODE_SET_TWO, 2, 8000, longint'(CUR_MAX));
      queue_request(MODE_COMPUTE, 2, 0, 0);
      queue_request(MODE_SET_ONE, 3, -100000, 500);
      queue_request(MODE_SET_TWO, 3, 100000, 500);
      queue_request(MODE_COMPUTE, 3, 0, 0);
      queue_request(MODE_SET_ONE, 4, longint'(CUR_MIN), 0);
      queue_request(MODE_SET_TWO, 4, longint'(CUR_MIN) + 100000, 400000);
      queue_request(MODE_COMPUTE, 4, 0, 0);
      queue_request(MODE_CLEAR_CH, 0, 0, 0);
      queue_request(MODE_UNUSED_HI, 1, 0, 0);
      queue_request(MODE_CLEAR_ALL, 12, 0, 0);
      wait_idle();

      program_span('0);
      add_random(300);
      wait_idle();

      program_span({SPAN_W{1'b1}});
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      add_random(150);
      wait_idle();

      program_span(SPAN_W'($urandom()));
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      add_random(300);
      wait_idle();

      program_span(SPAN_W'($urandom_range(0, 70000)));
      rsp_idle_on = 1'b0;
      add_random(250);
      wait_idle();

      program_span(MIN_SPAN_RESET);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      queue_request(MODE_UNUSED_LO, 2, 0, 0);
      add_random(150);
      wait_idle();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("responses never returned", 64'(expected_results.size()), '0);

      $display("%0d requests checked over %0d span settings: %0d computes passed, %0d failed",
               n_accepted, n_span_settings, n_calibrated, n_cal_rejected);
      $display("%0d applies on calibrated channels, %0d of them saturated",
               n_apply_cal, n_saturated);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/tpcc_pkg.sv
rtl/core/tpcc_if.sv
rtl/core/tpcc_div.sv
rtl/core/two_point_channel_calibration.sv
dv/two_point_channel_calibration_test.sv
